### rtl/core/imu_pp_pkg.sv
// ----------------------------------------------------------------------------
// imu_pp_pkg
// shared types, constants and helpers of the imu data packet parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imu_pp_pkg;

  // framing bytes
  localparam logic [7:0] PREAMBLE_BYTE   = 8'hFA;
  localparam logic [7:0] BUS_ID_BYTE     = 8'hFF;
  localparam logic [7:0] EXT_LENGTH_MARK = 8'hFF;

  // data item kinds
  localparam int unsigned NUM_KINDS  = 7;
  localparam logic [2:0] KIND_COUNTER = 3'd0;
  localparam logic [2:0] KIND_FINE    = 3'd1;
  localparam logic [2:0] KIND_EULER   = 3'd2;
  localparam logic [2:0] KIND_ACCEL   = 3'd3;
  localparam logic [2:0] KIND_RATE    = 3'd4;
  localparam logic [2:0] KIND_LATLON  = 3'd5;
  localparam logic [2:0] KIND_VEL     = 3'd6;
  localparam logic [2:0] KIND_SKIP    = 3'd7;

  // configuration register indexes
  localparam logic [2:0] REG_MSG_ID    = 3'd0;
  localparam logic [2:0] REG_KIND_BASE = 3'd1;

  // default ids
  localparam logic [7:0]  RST_MSG_ID = 8'd54;
  localparam logic [15:0] RST_KIND_ID [NUM_KINDS] = '{
    16'd4128, 16'd4192, 16'd8240, 16'd16416, 16'd32800, 16'd20544, 16'd53264
  };

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [7:0]                 msg_id;
    logic [NUM_KINDS-1:0][15:0] kind_id;
  } imu_pp_cfg_t;

  // one data byte of a known item, tagged for word assembly
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic [1:0] elem;
    logic       first;
    logic       last;
  } imu_pp_entry_t;

  // fixed item size in bytes
  function automatic logic [7:0] item_size(input logic [2:0] kind);
    logic [7:0] size;
    case (kind)
      KIND_COUNTER: size = 8'd2;
      KIND_FINE:    size = 8'd4;
      KIND_EULER:   size = 8'd12;
      KIND_ACCEL:   size = 8'd12;
      KIND_RATE:    size = 8'd12;
      KIND_LATLON:  size = 8'd8;
      KIND_VEL:     size = 8'd12;
      default:      size = 8'd0;
    endcase
    return size;
  endfunction

endpackage

`default_nettype wire

### rtl/core/imu_pp_front.sv
// ----------------------------------------------------------------------------
// imu_pp_front
// header check and data item walk, one byte per cycle while the queue has room
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_pp_front
  import imu_pp_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire imu_pp_cfg_t   cfg_i,
  input  wire logic          in_valid_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          frame_start_i,
  input  wire logic          q_full_i,
  output logic               in_stall_o,
  output logic               push_o,
  output imu_pp_entry_t      entry_o
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_BID      = 3'd1;
  localparam logic [2:0] PH_MID      = 3'd2;
  localparam logic [2:0] PH_LEN      = 3'd3;
  localparam logic [2:0] PH_ID_HI    = 3'd4;
  localparam logic [2:0] PH_ID_LO    = 3'd5;
  localparam logic [2:0] PH_ITEM_LEN = 3'd6;
  localparam logic [2:0] PH_DATA     = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  pos_q, pos_d;
  logic [15:0] item_id_q, item_id_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  wbc_q, wbc_d;
  logic [1:0]  elem_q, elem_d;
  logic [2:0]  kind_q, kind_d;

  logic       accept;
  logic [2:0] lookup;
  logic [7:0] left_dec;
  logic       word_done;
  logic [8:0] pos_inc;
  logic       in_payload;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // first matching register wins
  always_comb begin
    lookup = KIND_SKIP;
    for (int k = NUM_KINDS - 1; k >= 0; k--) begin
      if (cfg_i.kind_id[k] == item_id_q) lookup = 3'(k);
    end
  end

  assign left_dec  = left_q - 8'd1;
  assign word_done = (kind_q == KIND_COUNTER) ? (wbc_q == 2'd1) : (wbc_q == 2'd3);
  assign pos_inc   = {1'b0, pos_q} + 9'd1;
  assign in_payload = (phase_q inside {PH_ID_HI, PH_ID_LO, PH_ITEM_LEN, PH_DATA});

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    pos_d     = pos_q;
    item_id_d = item_id_q;
    left_d    = left_q;
    wbc_d     = wbc_q;
    elem_d    = elem_q;
    kind_d    = kind_q;
    push_o    = 1'b0;
    entry_o.data  = rx_byte_i;
    entry_o.kind  = kind_q;
    entry_o.elem  = elem_q;
    entry_o.first = (wbc_q == 2'd0);
    entry_o.last  = word_done;

    if (accept) begin
      if (frame_start_i) begin
        phase_d = (rx_byte_i == PREAMBLE_BYTE) ? PH_BID : PH_IDLE;
      end else begin
        case (phase_q)
          PH_BID: begin
            phase_d = (rx_byte_i == BUS_ID_BYTE) ? PH_MID : PH_IDLE;
          end
          PH_MID: begin
            phase_d = (rx_byte_i == cfg_i.msg_id) ? PH_LEN : PH_IDLE;
          end
          PH_LEN: begin
            if (rx_byte_i == EXT_LENGTH_MARK) begin
              phase_d = PH_IDLE;
            end else begin
              len_d   = rx_byte_i;
              pos_d   = '0;
              phase_d = (rx_byte_i == 8'd0) ? PH_IDLE : PH_ID_HI;
            end
          end
          PH_ID_HI: begin
            item_id_d = {rx_byte_i, 8'h00};
            phase_d   = PH_ID_LO;
          end
          PH_ID_LO: begin
            item_id_d = {item_id_q[15:8], rx_byte_i};
            phase_d   = PH_ITEM_LEN;
          end
          PH_ITEM_LEN: begin
            kind_d = lookup;
            wbc_d  = '0;
            elem_d = '0;
            left_d = (lookup == KIND_SKIP) ? rx_byte_i : item_size(lookup);
            phase_d = (left_d == 8'd0) ? PH_ID_HI : PH_DATA;
          end
          PH_DATA: begin
            if (kind_q != KIND_SKIP) begin
              push_o = 1'b1;
              if (word_done) begin
                wbc_d  = '0;
                elem_d = elem_q + 2'd1;
              end else begin
                wbc_d = wbc_q + 2'd1;
              end
            end
            left_d = left_dec;
            if (left_dec == 8'd0) phase_d = PH_ID_HI;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase

        // message end after exactly len payload bytes
        if (in_payload) begin
          pos_d = pos_inc[7:0];
          if (pos_inc >= {1'b0, len_q}) phase_d = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      len_q     <= '0;
      pos_q     <= '0;
      item_id_q <= '0;
      left_q    <= '0;
      wbc_q     <= '0;
      elem_q    <= '0;
      kind_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      item_id_q <= item_id_d;
      left_q    <= left_d;
      wbc_q     <= wbc_d;
      elem_q    <= elem_d;
      kind_q    <= kind_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/imu_pp_queue.sv
// ----------------------------------------------------------------------------
// imu_pp_queue
// short flop queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_pp_queue
  import imu_pp_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire imu_pp_entry_t entry_i,
  input  wire logic          pop_i,
  output imu_pp_entry_t      entry_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  imu_pp_entry_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

`default_nettype wire

### rtl/core/imu_pp_back.sv
// ----------------------------------------------------------------------------
// imu_pp_back
// word assembly and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_pp_back
  import imu_pp_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire imu_pp_entry_t entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [2:0]         field_kind_o,
  output logic [1:0]         element_index_o,
  output logic [31:0]        raw_value_o
);

  logic [31:0] shift_q, shift_d;
  logic        valid_q, valid_d;
  logic [2:0]  kind_q;
  logic [1:0]  elem_q;
  logic [31:0] value_q;
  logic        out_free;
  logic        load;

  assign out_free = !valid_q || !out_stall_i;
  assign pop_o    = !q_empty_i && (!entry_i.last || out_free);
  assign load     = pop_o && entry_i.last;

  // a new word starts fresh, so a word cut off earlier leaves nothing behind
  assign shift_d = entry_i.first ? {24'h000000, entry_i.data}
                                 : {shift_q[23:0], entry_i.data};

  always_comb begin
    valid_d = valid_q;
    if (out_valid_o && !out_stall_i) valid_d = 1'b0;
    if (load) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) shift_q <= shift_d;
    if (load) begin
      kind_q  <= entry_i.kind;
      elem_q  <= entry_i.elem;
      value_q <= shift_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign field_kind_o    = kind_q;
  assign element_index_o = elem_q;
  assign raw_value_o     = value_q;

endmodule

`default_nettype wire

### rtl/core/imu_data_packet_parser.sv
// ----------------------------------------------------------------------------
// imu_data_packet_parser
// streaming parser for one imu data message, words of each known item
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle (frame_start_i marks the first
// byte) and emits the words of known data items, each tagged with its kind
// and its element index. Sustained rate is one byte per cycle: the front
// checks the header (preamble, bus id, message id, standard length) and walks
// the data items in a single small state update per byte; the back shifts
// bytes of known items into a 32-bit word and loads the output register when
// a word completes. A queue of QueueDepth entries sits between them, so the
// front keeps taking bytes while a finished word waits on out_stall_i; input
// stalls only when that queue is full. With no backpressure, the last
// byte of a word passes the queue and then the output register. Configuration
// writes are always ready and must land only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module imu_data_packet_parser
  import imu_pp_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // byte stream in
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_start_i,
  // words out
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       field_kind_o,
  output logic [1:0]       element_index_o,
  output logic [31:0]      raw_value_o
);

  imu_pp_cfg_t   cfg_q;
  imu_pp_entry_t push_entry, head_entry;
  logic          push, pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  // register file: message id first, then the seven item ids in kind order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.msg_id <= RST_MSG_ID;
      for (int k = 0; k < NUM_KINDS; k++) cfg_q.kind_id[k] <= RST_KIND_ID[k];
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_MSG_ID) cfg_q.msg_id <= cfg_data_i[7:0];
      for (int k = 0; k < NUM_KINDS; k++) begin
        if (cfg_index_i == REG_KIND_BASE + 3'(k)) cfg_q.kind_id[k] <= cfg_data_i;
      end
    end
  end

  // front: header check, item walk, tags data bytes of known items
  imu_pp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  // decoupling queue
  imu_pp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: word assembly and result register
  imu_pp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .entry_i         (head_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .field_kind_o    (field_kind_o),
    .element_index_o (element_index_o),
    .raw_value_o     (raw_value_o)
  );

endmodule

`default_nettype wire

### rtl/core/imu_pp_checker.sv
// ----------------------------------------------------------------------------
// imu_pp_checker
// port-level checks of the parser output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_pp_checker
  import imu_pp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  field_kind_o,
  input wire logic [1:0]  element_index_o,
  input wire logic [31:0] raw_value_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(raw_value_o))
    else $error("stalled item dropped or changed");

  a_no_skip_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> field_kind_o != KIND_SKIP)
    else $error("skipped item produced a word");

  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (field_kind_o == KIND_COUNTER || field_kind_o == KIND_FINE)
      |-> element_index_o == 2'd0)
    else $error("single word item with nonzero element");

  a_counter_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_kind_o == KIND_COUNTER |-> raw_value_o[31:16] == 16'h0000)
    else $error("counter word not zero extended");

  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_kind_o == KIND_LATLON |-> element_index_o != 2'd2 &&
      element_index_o != 2'd3)
    else $error("lat lon element out of range");

endmodule

bind imu_data_packet_parser imu_pp_checker u_imu_pp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .field_kind_o    (field_kind_o),
  .element_index_o (element_index_o),
  .raw_value_o     (raw_value_o)
);

`default_nettype wire
